// ----- hdl/dgr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the CAN datagram reassembly block.
package dgr_pkg;

    // Slot lengths reach the largest datagram plus one frame (72 + 8).
    localparam int LEN_W      = 7;
    localparam int SLOT_IDX_W = 4;
    localparam int ROW_IDX_W  = 4;

    localparam logic [15:0] REJECT_CODE = 16'h2040;

    localparam logic OUT_CHUNK  = 1'b0;
    localparam logic OUT_REJECT = 1'b1;

    typedef enum logic [1:0] {
        KIND_SINGLE = 2'd0,
        KIND_FIRST  = 2'd1,
        KIND_MIDDLE = 2'd2,
        KIND_LAST   = 2'd3
    } t_kind;

    typedef logic [7:0][7:0] t_bytes;

    typedef struct packed {
        logic                  hit;
        logic [SLOT_IDX_W-1:0] hit_idx;
        logic                  free;
        logic [SLOT_IDX_W-1:0] free_idx;
        logic [LEN_W-1:0]      have;
    } t_look;

    typedef struct packed {
        logic                  we;
        logic [SLOT_IDX_W-1:0] idx;
        logic                  valid;
        logic [11:0]           peer;
        logic [LEN_W-1:0]      length;
    } t_upd;

    typedef struct packed {
        logic                  we;
        logic [SLOT_IDX_W-1:0] slot;
        logic [LEN_W-1:0]      base;
        logic [3:0]            len;
        t_bytes                data;
    } t_wr;

    typedef struct packed {
        logic                  re;
        logic [SLOT_IDX_W-1:0] slot;
        logic [ROW_IDX_W-1:0]  row;
    } t_rd;

endpackage

// ----- hdl/dgr_slot_table.sv -----
`timescale 1ns / 1ps
// Reassembly slot table: per-slot valid, source alias and length, with lookup.
module dgr_slot_table #(
    parameter int SLOT_COUNT = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [11:0]   i_src,
    input  dgr_pkg::t_upd i_upd,
    output dgr_pkg::t_look o_look
);

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    logic                      r_valid [SLOT_COUNT];
    logic [11:0]               r_src   [SLOT_COUNT];
    logic [dgr_pkg::LEN_W-1:0] r_len   [SLOT_COUNT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_valid[i] <= 1'b0;
                r_src[i]   <= '0;
                r_len[i]   <= '0;
            end
        end else if (i_upd.we) begin
            r_valid[i_upd.idx[SLOT_W-1:0]] <= i_upd.valid;
            r_src[i_upd.idx[SLOT_W-1:0]]   <= i_upd.peer;
            r_len[i_upd.idx[SLOT_W-1:0]]   <= i_upd.length;
        end
    end

    // Scanning from the top down leaves the lowest matching index in place.
    always_comb begin
        o_look = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (r_valid[i] && r_src[i] == i_src) begin
                o_look.hit     = 1'b1;
                o_look.hit_idx = dgr_pkg::SLOT_IDX_W'(i);
                o_look.have    = r_len[i];
            end
            if (!r_valid[i]) begin
                o_look.free     = 1'b1;
                o_look.free_idx = dgr_pkg::SLOT_IDX_W'(i);
            end
        end
    end

endmodule

// ----- hdl/dgr_buffer.sv -----
`timescale 1ns / 1ps
// Datagram byte buffer: eight byte-wide banks, one row of eight bytes per address.
module dgr_buffer #(
    parameter int SLOT_COUNT         = 4,
    parameter int MAX_DATAGRAM_BYTES = 72
) (
    input  logic            i_clk,
    input  dgr_pkg::t_wr    i_wr,
    input  dgr_pkg::t_rd    i_rd,
    output dgr_pkg::t_bytes o_rdata
);

    localparam int ROWS   = (MAX_DATAGRAM_BYTES + 7) / 8;
    localparam int DEPTH  = SLOT_COUNT * ROWS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [7:0]        r_mem [8][DEPTH];
    logic [7:0]        r_q   [8];
    logic              w_en   [8];
    logic [ADDR_W-1:0] w_addr [8];
    logic [7:0]        w_data [8];
    logic [ADDR_W-1:0] w_raddr;

    // Byte j of a frame lands at position base + j: bank (base + j) mod 8,
    // row (base + j) / 8. Each bank takes at most one byte per frame.
    always_comb begin
        logic [2:0]                sel;
        logic [dgr_pkg::LEN_W-1:0] pos;
        for (int b = 0; b < 8; b++) begin
            sel       = 3'(b) - i_wr.base[2:0];
            pos       = i_wr.base + dgr_pkg::LEN_W'(sel);
            w_en[b]   = i_wr.we && ({1'b0, sel} < i_wr.len);
            w_addr[b] = ADDR_W'(i_wr.slot[SLOT_W-1:0]) * ADDR_W'(ROWS)
                      + ADDR_W'(pos[ROW_W+2:3]);
            w_data[b] = i_wr.data[sel];
        end
    end

    assign w_raddr = ADDR_W'(i_rd.slot[SLOT_W-1:0]) * ADDR_W'(ROWS)
                   + ADDR_W'(i_rd.row[ROW_W-1:0]);

    always_ff @(posedge i_clk) begin
        for (int b = 0; b < 8; b++) begin
            if (w_en[b]) begin
                r_mem[b][w_addr[b]] <= w_data[b];
            end
            if (i_rd.re) begin
                r_q[b] <= r_mem[b][w_raddr];
            end
        end
    end

    always_comb begin
        for (int b = 0; b < 8; b++) begin
            o_rdata[b] = r_q[b];
        end
    end

endmodule

// ----- hdl/can_datagram_reassembly.sv -----
`timescale 1ns / 1ps
// CAN datagram reassembly: frames in, whole datagrams out as eight-byte chunks.
//
// Input channel (i_in_valid / o_in_ready) takes one frame per beat. Frames whose
// destination alias differs from the configured alias are dropped at once. Output
// channel (o_out_valid / i_out_ready) carries chunks and reject beats through a
// one-entry output register, so a new frame is taken while the last beat waits.
// Steps per frame: a dropped frame ends in idle; any other frame passes the slot
// table lookup (S_LOOK) and the table update or buffer write (S_ACT). A single
// frame or reject then issues its beat (S_RESP); a last frame reads each buffer
// row by a registered read (S_READ) and emits it (S_WAIT), up to nine chunks.
// A stalled receiver holds the block in its emit step; nothing is dropped.
// Reset (i_rst_n, synchronous) clears the alias register, all slots and the
// output register. The byte buffer is not cleared: a slot only ever reads back
// bytes that its current datagram wrote. The alias register is to be written
// (i_cfg_we / i_cfg_wdata) only while idle; the block does not enforce this.
module can_datagram_reassembly #(
    parameter int SLOT_COUNT         = 4,
    parameter int MAX_DATAGRAM_BYTES = 72
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [11:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [11:0] i_dest_alias,
    input  logic [11:0] i_source_alias,
    input  logic [3:0]  i_frame_len,
    input  logic [7:0]  i_in_byte0,
    input  logic [7:0]  i_in_byte1,
    input  logic [7:0]  i_in_byte2,
    input  logic [7:0]  i_in_byte3,
    input  logic [7:0]  i_in_byte4,
    input  logic [7:0]  i_in_byte5,
    input  logic [7:0]  i_in_byte6,
    input  logic [7:0]  i_in_byte7,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_out_kind,
    output logic [11:0] o_peer_alias,
    output logic [3:0]  o_chunk_len,
    output logic        o_last_chunk,
    output logic [7:0]  o_out_byte0,
    output logic [7:0]  o_out_byte1,
    output logic [7:0]  o_out_byte2,
    output logic [7:0]  o_out_byte3,
    output logic [7:0]  o_out_byte4,
    output logic [7:0]  o_out_byte5,
    output logic [7:0]  o_out_byte6,
    output logic [7:0]  o_out_byte7
);

    localparam int LEN_W = dgr_pkg::LEN_W;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_LOOK = 6'b000010,
        S_ACT  = 6'b000100,
        S_READ = 6'b001000,
        S_WAIT = 6'b010000,
        S_RESP = 6'b100000
    } t_state;

    function automatic dgr_pkg::t_bytes mask_bytes(dgr_pkg::t_bytes d, logic [3:0] n);
        dgr_pkg::t_bytes m;
        for (int j = 0; j < 8; j++) begin
            m[j] = (4'(j) < n) ? d[j] : 8'h00;
        end
        return m;
    endfunction

    // Control registers
    t_state      r_state, n_state;
    logic [11:0] r_our_alias;
    logic        r_out_valid, n_out_valid;

    // Payload registers
    dgr_pkg::t_kind          r_kind;
    logic [11:0]             r_src;
    logic [3:0]              r_len;
    dgr_pkg::t_bytes         r_data;
    dgr_pkg::t_look          r_look, n_look;
    logic [dgr_pkg::SLOT_IDX_W-1:0] r_slot, n_slot;
    logic [LEN_W-1:0]        r_total, n_total;
    logic [dgr_pkg::ROW_IDX_W-1:0]  r_row, n_row;
    logic                    r_pend_kind, n_pend_kind;
    logic [3:0]              r_pend_len, n_pend_len;
    dgr_pkg::t_bytes         r_pend_bytes, n_pend_bytes;
    logic                    r_out_kind, n_out_kind;
    logic [11:0]             r_out_peer, n_out_peer;
    logic [3:0]              r_out_len, n_out_len;
    logic                    r_out_last, n_out_last;
    dgr_pkg::t_bytes         r_out_bytes, n_out_bytes;

    logic            w_accept;
    logic            w_out_free;
    dgr_pkg::t_look  w_look;
    dgr_pkg::t_upd   w_upd;
    dgr_pkg::t_wr    w_wr;
    dgr_pkg::t_rd    w_rd;
    dgr_pkg::t_bytes w_rdata;
    dgr_pkg::t_bytes w_reject_bytes;
    logic [LEN_W-1:0] w_sum;
    logic [LEN_W-1:0] w_rem;
    logic             w_chunk_last;
    logic [3:0]       w_clen;
    logic [dgr_pkg::SLOT_IDX_W-1:0] w_first_slot;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    assign w_sum        = r_look.have + LEN_W'(r_len);
    assign w_rem        = r_total - LEN_W'({r_row, 3'b000});
    assign w_chunk_last = (w_rem <= LEN_W'(8));
    assign w_clen       = w_chunk_last ? w_rem[3:0] : 4'd8;
    assign w_first_slot = r_look.hit ? r_look.hit_idx : r_look.free_idx;

    always_comb begin
        w_reject_bytes    = '0;
        w_reject_bytes[0] = dgr_pkg::REJECT_CODE[15:8];
        w_reject_bytes[1] = dgr_pkg::REJECT_CODE[7:0];
    end

    dgr_slot_table #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_src   (r_src),
        .i_upd   (w_upd),
        .o_look  (w_look)
    );

    dgr_buffer #(
        .SLOT_COUNT         (SLOT_COUNT),
        .MAX_DATAGRAM_BYTES (MAX_DATAGRAM_BYTES)
    ) u_buffer (
        .i_clk   (i_clk),
        .i_wr    (w_wr),
        .i_rd    (w_rd),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_look       = r_look;
        n_slot       = r_slot;
        n_total      = r_total;
        n_row        = r_row;
        n_pend_kind  = r_pend_kind;
        n_pend_len   = r_pend_len;
        n_pend_bytes = r_pend_bytes;
        n_out_kind   = r_out_kind;
        n_out_peer   = r_out_peer;
        n_out_len    = r_out_len;
        n_out_last   = r_out_last;
        n_out_bytes  = r_out_bytes;
        w_upd        = '0;
        w_wr         = '0;
        w_rd         = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept && i_dest_alias == r_our_alias) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_look  = w_look;
                n_state = S_ACT;
            end
            S_ACT: begin
                // Reject is the default outcome; the branches below override it.
                n_pend_kind  = dgr_pkg::OUT_REJECT;
                n_pend_len   = 4'd0;
                n_pend_bytes = w_reject_bytes;
                n_state      = S_RESP;
                unique case (r_kind)
                    dgr_pkg::KIND_SINGLE: begin
                        n_pend_kind  = dgr_pkg::OUT_CHUNK;
                        n_pend_len   = r_len;
                        n_pend_bytes = mask_bytes(r_data, r_len);
                    end
                    dgr_pkg::KIND_FIRST: begin
                        if (r_look.hit || r_look.free) begin
                            w_upd.we     = 1'b1;
                            w_upd.idx    = w_first_slot;
                            w_upd.valid  = 1'b1;
                            w_upd.peer   = r_src;
                            w_upd.length = LEN_W'(r_len);
                            w_wr.we      = 1'b1;
                            w_wr.slot    = w_first_slot;
                            w_wr.base    = '0;
                            w_wr.len     = r_len;
                            w_wr.data    = r_data;
                            n_state      = S_IDLE;
                        end
                    end
                    dgr_pkg::KIND_MIDDLE, dgr_pkg::KIND_LAST: begin
                        if (r_look.hit && w_sum > LEN_W'(MAX_DATAGRAM_BYTES)) begin
                            // Overflow frees the slot and rejects.
                            w_upd.we   = 1'b1;
                            w_upd.idx  = r_look.hit_idx;
                            w_upd.peer = r_src;
                        end else if (r_look.hit) begin
                            w_wr.we      = 1'b1;
                            w_wr.slot    = r_look.hit_idx;
                            w_wr.base    = r_look.have;
                            w_wr.len     = r_len;
                            w_wr.data    = r_data;
                            w_upd.we     = 1'b1;
                            w_upd.idx    = r_look.hit_idx;
                            w_upd.peer   = r_src;
                            if (r_kind == dgr_pkg::KIND_LAST) begin
                                // The slot is freed now; its bytes stay in the
                                // buffer until the next first frame overwrites them.
                                n_total = w_sum;
                                n_slot  = r_look.hit_idx;
                                n_row   = '0;
                                n_state = S_READ;
                            end else begin
                                w_upd.valid  = 1'b1;
                                w_upd.length = w_sum;
                                n_state      = S_IDLE;
                            end
                        end
                    end
                endcase
            end
            S_READ: begin
                w_rd.re   = 1'b1;
                w_rd.slot = r_slot;
                w_rd.row  = r_row;
                n_state   = S_WAIT;
            end
            S_WAIT: begin
                // The read data register holds while the receiver stalls.
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = dgr_pkg::OUT_CHUNK;
                    n_out_peer  = r_src;
                    n_out_len   = w_clen;
                    n_out_last  = w_chunk_last;
                    n_out_bytes = mask_bytes(w_rdata, w_clen);
                    if (w_chunk_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_row   = r_row + 1'b1;
                        n_state = S_READ;
                    end
                end
            end
            S_RESP: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = r_pend_kind;
                    n_out_peer  = r_src;
                    n_out_len   = r_pend_len;
                    n_out_last  = 1'b1;
                    n_out_bytes = r_pend_bytes;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_our_alias <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_our_alias <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind    <= dgr_pkg::t_kind'(i_kind);
            r_src     <= i_source_alias;
            r_len     <= (i_frame_len > 4'd8) ? 4'd8 : i_frame_len;
            r_data[0] <= i_in_byte0;
            r_data[1] <= i_in_byte1;
            r_data[2] <= i_in_byte2;
            r_data[3] <= i_in_byte3;
            r_data[4] <= i_in_byte4;
            r_data[5] <= i_in_byte5;
            r_data[6] <= i_in_byte6;
            r_data[7] <= i_in_byte7;
        end
        r_look       <= n_look;
        r_slot       <= n_slot;
        r_total      <= n_total;
        r_row        <= n_row;
        r_pend_kind  <= n_pend_kind;
        r_pend_len   <= n_pend_len;
        r_pend_bytes <= n_pend_bytes;
        r_out_kind   <= n_out_kind;
        r_out_peer   <= n_out_peer;
        r_out_len    <= n_out_len;
        r_out_last   <= n_out_last;
        r_out_bytes  <= n_out_bytes;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_kind   = r_out_kind;
    assign o_peer_alias = r_out_peer;
    assign o_chunk_len  = r_out_len;
    assign o_last_chunk = r_out_last;
    assign o_out_byte0  = r_out_bytes[0];
    assign o_out_byte1  = r_out_bytes[1];
    assign o_out_byte2  = r_out_bytes[2];
    assign o_out_byte3  = r_out_bytes[3];
    assign o_out_byte4  = r_out_bytes[4];
    assign o_out_byte5  = r_out_bytes[5];
    assign o_out_byte6  = r_out_bytes[6];
    assign o_out_byte7  = r_out_bytes[7];

endmodule

// ----- hdl/dgr_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks on the output beats of the datagram reassembly block.
module dgr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_out_kind,
    input logic [3:0]  o_chunk_len,
    input logic        o_last_chunk,
    input logic [7:0]  o_out_byte0,
    input logic [7:0]  o_out_byte1,
    input logic [7:0]  o_out_byte7
);

    // A beat that is not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output beat withdrawn before it was taken");

    a_reject_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_kind == dgr_pkg::OUT_REJECT |->
            o_chunk_len == 4'd0 && o_last_chunk &&
            o_out_byte0 == dgr_pkg::REJECT_CODE[15:8] &&
            o_out_byte1 == dgr_pkg::REJECT_CODE[7:0])
        else $error("malformed reject beat");

    // Only the final chunk of a datagram may be short.
    a_full_inner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_chunk |->
            o_out_kind == dgr_pkg::OUT_CHUNK && o_chunk_len == 4'd8)
        else $error("inner chunk is not a full eight-byte chunk");

    a_len_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_kind == dgr_pkg::OUT_CHUNK |->
            o_chunk_len <= 4'd8 && (o_chunk_len == 4'd8 || o_out_byte7 == 8'h00))
        else $error("chunk length out of range or unused byte not cleared");

endmodule

bind can_datagram_reassembly dgr_checker u_dgr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_out_kind   (o_out_kind),
    .o_chunk_len  (o_chunk_len),
    .o_last_chunk (o_last_chunk),
    .o_out_byte0  (o_out_byte0),
    .o_out_byte1  (o_out_byte1),
    .o_out_byte7  (o_out_byte7)
);

// ----- tb/tb_can_datagram_reassembly.sv -----
`timescale 1ns / 1ps
// CAN datagram reassembly bench: directed and random frames vs a built-in slot-table predictor.
module tb_can_datagram_reassembly;

    localparam int NSLOTS      = 4;
    localparam int DG_MAX      = 72;
    localparam int SETTLE      = 50;
    localparam int QUIET_LIMIT = 3000;

    typedef struct packed {
        dgr_pkg::t_kind  kind;
        logic [11:0]     dest;
        logic [11:0]     src;
        logic [3:0]      len;
        dgr_pkg::t_bytes data;
    } t_frame;

    typedef struct packed {
        logic            kind;
        logic [11:0]     peer;
        logic [3:0]      len;
        logic            last;
        dgr_pkg::t_bytes data;
    } t_chunk;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [11:0] i_cfg_wdata = '0;
    logic        i_in_valid  = 1'b0;
    logic        i_out_ready = 1'b0;
    t_frame      cur_frame   = '0;

    logic        o_in_ready;
    logic        o_out_valid;
    logic        o_out_kind;
    logic [11:0] o_peer_alias;
    logic [3:0]  o_chunk_len;
    logic        o_last_chunk;
    logic [7:0]  o_out_byte0, o_out_byte1, o_out_byte2, o_out_byte3;
    logic [7:0]  o_out_byte4, o_out_byte5, o_out_byte6, o_out_byte7;

    // Predictor copy of the alias register and the slot table.
    logic [11:0] rx_alias = '0;
    bit          slot_open [NSLOTS] = '{default: 1'b0};
    logic [11:0] slot_owner[NSLOTS] = '{default: '0};
    int          slot_fill [NSLOTS] = '{default: 0};
    logic [7:0]  dg_buf    [NSLOTS][DG_MAX];

    t_frame frames_to_send[$];
    t_chunk chunks_due[$];
    int     errors      = 0;
    int     quiet_count = 0;
    bit     calm        = 1'b0;

    always #5 i_clk = ~i_clk;

    can_datagram_reassembly #(
        .SLOT_COUNT        (NSLOTS),
        .MAX_DATAGRAM_BYTES(DG_MAX)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (cur_frame.kind),
        .i_dest_alias  (cur_frame.dest),
        .i_source_alias(cur_frame.src),
        .i_frame_len   (cur_frame.len),
        .i_in_byte0    (cur_frame.data[0]),
        .i_in_byte1    (cur_frame.data[1]),
        .i_in_byte2    (cur_frame.data[2]),
        .i_in_byte3    (cur_frame.data[3]),
        .i_in_byte4    (cur_frame.data[4]),
        .i_in_byte5    (cur_frame.data[5]),
        .i_in_byte6    (cur_frame.data[6]),
        .i_in_byte7    (cur_frame.data[7]),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_kind    (o_out_kind),
        .o_peer_alias  (o_peer_alias),
        .o_chunk_len   (o_chunk_len),
        .o_last_chunk  (o_last_chunk),
        .o_out_byte0   (o_out_byte0),
        .o_out_byte1   (o_out_byte1),
        .o_out_byte2   (o_out_byte2),
        .o_out_byte3   (o_out_byte3),
        .o_out_byte4   (o_out_byte4),
        .o_out_byte5   (o_out_byte5),
        .o_out_byte6   (o_out_byte6),
        .o_out_byte7   (o_out_byte7)
    );

    function automatic bit skip_cycle();
        return !calm && ($urandom_range(99) < 18);
    endfunction

    function automatic dgr_pkg::t_bytes rand_bytes();
        return dgr_pkg::t_bytes'({$urandom, $urandom});
    endfunction

    function automatic logic [3:0] rand_len();
        if ($urandom_range(9) == 0)
            return 4'($urandom_range(15, 9));
        return 4'($urandom_range(8));
    endfunction

    function automatic t_frame mk_frame(dgr_pkg::t_kind k, logic [11:0] d, logic [11:0] s,
                                        logic [3:0] n, dgr_pkg::t_bytes b);
        t_frame f;
        f.kind = k;
        f.dest = d;
        f.src  = s;
        f.len  = n;
        f.data = b;
        return f;
    endfunction

    function automatic t_chunk mk_chunk(logic [11:0] peer, int n, bit last,
                                        dgr_pkg::t_bytes b);
        t_chunk c;
        c.kind = dgr_pkg::OUT_CHUNK;
        c.peer = peer;
        c.len  = 4'(n);
        c.last = last;
        for (int j = 0; j < 8; j++)
            c.data[j] = (j < n) ? b[j] : 8'h00;
        return c;
    endfunction

    function automatic t_chunk mk_reject(logic [11:0] peer);
        t_chunk c;
        c         = '0;
        c.kind    = dgr_pkg::OUT_REJECT;
        c.peer    = peer;
        c.last    = 1'b1;
        c.data[0] = dgr_pkg::REJECT_CODE[15:8];
        c.data[1] = dgr_pkg::REJECT_CODE[7:0];
        return c;
    endfunction

    function automatic int find_open_slot(logic [11:0] src);
        for (int i = 0; i < NSLOTS; i++)
            if (slot_open[i] && slot_owner[i] == src)
                return i;
        return -1;
    endfunction

    function automatic int find_idle_slot();
        for (int i = 0; i < NSLOTS; i++)
            if (!slot_open[i])
                return i;
        return -1;
    endfunction

    // Updates the slot table for one accepted frame and queues the beats it causes.
    task automatic reassemble_frame(t_frame f);
        int              n;
        int              s;
        int              have;
        int              pos;
        int              c;
        dgr_pkg::t_bytes row;
        n = (f.len > 8) ? 8 : int'(f.len);
        if (f.dest != rx_alias)
            return;
        if (f.kind == dgr_pkg::KIND_SINGLE) begin
            chunks_due.push_back(mk_chunk(f.src, n, 1'b1, f.data));
            return;
        end
        s = find_open_slot(f.src);
        if (f.kind == dgr_pkg::KIND_FIRST) begin
            if (s < 0)
                s = find_idle_slot();
            if (s < 0) begin
                chunks_due.push_back(mk_reject(f.src));
                return;
            end
            slot_open[s]  = 1'b1;
            slot_owner[s] = f.src;
            for (int j = 0; j < n; j++)
                dg_buf[s][j] = f.data[j];
            slot_fill[s] = n;
            return;
        end
        if (s < 0) begin
            chunks_due.push_back(mk_reject(f.src));
            return;
        end
        have = slot_fill[s];
        if (have + n > DG_MAX) begin
            slot_open[s] = 1'b0;
            slot_fill[s] = 0;
            chunks_due.push_back(mk_reject(f.src));
            return;
        end
        for (int j = 0; j < n; j++)
            dg_buf[s][have + j] = f.data[j];
        have += n;
        slot_fill[s] = have;
        if (f.kind == dgr_pkg::KIND_MIDDLE)
            return;
        if (have == 0) begin
            chunks_due.push_back(mk_chunk(f.src, 0, 1'b1, '0));
        end else begin
            pos = 0;
            while (pos < have) begin
                c   = (have - pos > 8) ? 8 : have - pos;
                row = '0;
                for (int j = 0; j < 8; j++)
                    if (j < c)
                        row[j] = dg_buf[s][pos + j];
                chunks_due.push_back(mk_chunk(f.src, c, pos + c >= have, row));
                pos += c;
            end
        end
        slot_open[s] = 1'b0;
        slot_fill[s] = 0;
    endtask

    task automatic note_field(string what, int want, int got);
        if (want != got) begin
            $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
            errors++;
        end
    endtask

    task automatic check_beat();
        t_chunk got;
        t_chunk want;
        got.kind = o_out_kind;
        got.peer = o_peer_alias;
        got.len  = o_chunk_len;
        got.last = o_last_chunk;
        got.data = {o_out_byte7, o_out_byte6, o_out_byte5, o_out_byte4,
                    o_out_byte3, o_out_byte2, o_out_byte1, o_out_byte0};
        if (chunks_due.size() == 0) begin
            $display("%0t: beat with no expectation, expected none actual %h", $time, got);
            errors++;
            return;
        end
        want = chunks_due.pop_front();
        note_field("out_kind", want.kind, got.kind);
        note_field("peer_alias", want.peer, got.peer);
        note_field("chunk_len", want.len, got.len);
        note_field("last_chunk", want.last, got.last);
        for (int j = 0; j < 8; j++)
            note_field($sformatf("out_byte%0d", j), want.data[j], got.data[j]);
    endtask

    // Frame driver: a beat is held until accepted, then the next one is offered.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                reassemble_frame(cur_frame);
            if (!i_in_valid || o_in_ready) begin
                if (frames_to_send.size() != 0 && !skip_cycle()) begin
                    cur_frame  <= frames_to_send.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready)
                check_beat();
            i_out_ready <= !skip_cycle();
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && o_in_ready) ||
            (o_out_valid && i_out_ready))
            quiet_count <= 0;
        else
            quiet_count <= quiet_count + 1;
    end

    initial begin
        wait (quiet_count >= QUIET_LIMIT);
        $display("%0t: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
        $display("tb: failure");
        $finish;
    end

    task automatic write_alias(logic [11:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        rx_alias     = value;
    endtask

    // Waits for every frame to go in and every beat to come out, then lets
    // the block finish any frame that produced no result. The falling edge
    // sees the driver and the predictor settled for the cycle.
    task automatic wait_until_quiet();
        while (frames_to_send.size() != 0 || i_in_valid || chunks_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic queue_directed(logic [11:0] a);
        frames_to_send.push_back(mk_frame(dgr_pkg::KIND_SINGLE, a, 12'h000, 4'd0,
                                          rand_bytes()));
        frames_to_send.push_back(mk_frame(dgr_pkg::KIND_SINGLE, a, 12'hFFF, 4'd8, '1));
        frames_to_send.push_back(mk_frame(dgr_pkg::KIND_SINGLE, a ^ 12'h001, 12'd7, 4'd8,
                                          rand_bytes()));
        frames_to_send.push_back(mk_frame(dgr_pkg::KIND_SINGLE, a, 12'd7, 4'd15,
                                          rand_bytes()));
        // Middle and last from a source with no open slot.
        frames_to_send.push_back(mk_frame(dgr_pkg::KIND_MIDDLE, a, 12'd5, 4'd4, rand_bytes()));
        frames_to_send.push_back(mk_frame(dgr_pkg::KIND_LAST, a, 12'd5, 4'd4, rand_bytes()));
        frames_to_send.push_back(mk_frame(dgr_pkg::KIND_FIRST, a, 12'd10, 4'd8, rand_bytes()));
        frames_to_send.push_back(mk_frame(dgr_pkg::KIND_MIDDLE, a, 12'd10, 4'd8,
                                          rand_bytes()));
        frames_to_send.push_back(mk_frame(dgr_pkg::KIND_LAST, a, 12'd10, 4'd3, rand_bytes()));
        // A first frame overwrites the open slot, then an empty datagram closes it.
        frames_to_send.push_back(mk_frame(dgr_pkg::KIND_FIRST, a, 12'd20, 4'd5, rand_bytes()));
        frames_to_send.push_back(mk_frame(dgr_pkg::KIND_FIRST, a, 12'd20, 4'd0, rand_bytes()));
        frames_to_send.push_back(mk_frame(dgr_pkg::KIND_LAST, a, 12'd20, 4'd0, rand_bytes()));
        for (int i = 1; i <= NSLOTS; i++)
            frames_to_send.push_back(mk_frame(dgr_pkg::KIND_FIRST, a, 12'(i), 4'd8,
                                              rand_bytes()));
        frames_to_send.push_back(mk_frame(dgr_pkg::KIND_FIRST, a, 12'd5, 4'd8, rand_bytes()));
        // Fill source 1 to the maximum length, then overflow it with a last frame.
        for (int i = 0; i < 8; i++)
            frames_to_send.push_back(mk_frame(dgr_pkg::KIND_MIDDLE, a, 12'd1,
                                              (i == 3) ? 4'd12 : 4'd8, rand_bytes()));
        frames_to_send.push_back(mk_frame(dgr_pkg::KIND_LAST, a, 12'd1, 4'd1, rand_bytes()));
    endtask

    function automatic logic [11:0] pick_source();
        if ($urandom_range(9) != 0)
            return 12'($urandom_range(6, 1));
        return 12'($urandom_range(4095));
    endfunction

    // One datagram from a source: first, some middles, last. Long ones run
    // to the maximum length or one or two frames past it.
    task automatic build_datagram(logic [11:0] a, logic [11:0] src, ref t_frame q[$]);
        int             n_mid;
        int             r;
        bit             full;
        dgr_pkg::t_kind k;
        r     = $urandom_range(99);
        n_mid = (r < 60) ? $urandom_range(2) : (r < 85) ? $urandom_range(6, 3) :
                (r < 95) ? 7 : $urandom_range(9, 8);
        full  = (n_mid >= 7);
        for (int i = 0; i <= n_mid + 1; i++) begin
            k = (i == 0) ? dgr_pkg::KIND_FIRST :
                (i == n_mid + 1) ? dgr_pkg::KIND_LAST : dgr_pkg::KIND_MIDDLE;
            q.push_back(mk_frame(k, a, src,
                                 full ? ($urandom_range(1) ? 4'd8 : 4'($urandom_range(15, 9)))
                                      : rand_len(),
                                 rand_bytes()));
        end
    endtask

    task automatic queue_random(logic [11:0] a, int target);
        int          count;
        int          r;
        t_frame      qa[$];
        t_frame      qb[$];
        logic [11:0] d;
        count = 0;
        while (count < target) begin
            r = $urandom_range(99);
            qa.delete();
            qb.delete();
            if (r < 15) begin
                frames_to_send.push_back(mk_frame(dgr_pkg::KIND_SINGLE, a, pick_source(),
                                                  rand_len(), rand_bytes()));
                count++;
            end else if (r < 65) begin
                // Two datagrams from randomly picked sources, interleaved beat by beat.
                build_datagram(a, pick_source(), qa);
                build_datagram(a, pick_source(), qb);
                count += qa.size() + qb.size();
                while (qa.size() != 0 || qb.size() != 0) begin
                    if (qb.size() == 0 || (qa.size() != 0 && $urandom_range(1)))
                        frames_to_send.push_back(qa.pop_front());
                    else
                        frames_to_send.push_back(qb.pop_front());
                end
            end else if (r < 75) begin
                // Broken datagram: its first or its last frame is missing.
                build_datagram(a, pick_source(), qa);
                if ($urandom_range(1))
                    void'(qa.pop_front());
                else
                    void'(qa.pop_back());
                count += qa.size();
                while (qa.size() != 0)
                    frames_to_send.push_back(qa.pop_front());
            end else if (r < 90) begin
                d = $urandom_range(1) ? a : 12'($urandom_range(4095));
                frames_to_send.push_back(mk_frame(dgr_pkg::t_kind'($urandom_range(3)), d,
                                                  pick_source(), 4'($urandom_range(15)),
                                                  rand_bytes()));
                if (d == a)
                    count++;
            end else begin
                d = a ^ (12'd1 << $urandom_range(11));
                frames_to_send.push_back(mk_frame(dgr_pkg::t_kind'($urandom_range(3)), d,
                                                  pick_source(), rand_len(), rand_bytes()));
            end
        end
    endtask

    initial begin
        logic [11:0] aliases[4];
        aliases[0] = 12'hFFF;
        aliases[1] = 12'($urandom_range(4094, 1));
        aliases[2] = 12'($urandom_range(4094, 1));
        aliases[3] = 12'h000;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_alias(12'h000);
        queue_directed(12'h000);
        wait_until_quiet();
        for (int p = 0; p < 4; p++) begin
            write_alias(aliases[p]);
            // One phase runs with both sides always ready.
            calm = (p == 2);
            queue_random(aliases[p], 40);
            wait_until_quiet();
        end
        if (chunks_due.size() != 0) begin
            $display("%0t: %0d expected beats never arrived", $time, chunks_due.size());
            errors++;
        end
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
